FILE: sv/teket_pkg.sv
`default_nettype none

package teket_pkg;

   // Character codes used by the translator.
   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_ESC   = 8'd27;
   localparam logic [7:0] CHAR_DEL   = 8'd127;
   localparam logic [7:0] CHAR_LBRK  = 8'h5B;
   localparam logic [7:0] CHAR_TWO   = 8'h32;
   localparam logic [7:0] CHAR_THREE = 8'h33;
   localparam logic [7:0] CHAR_FOUR  = 8'h34;
   localparam logic [7:0] CHAR_TILDE = 8'h7E;
   localparam logic [7:0] CHAR_UC_D  = 8'h44;
   localparam logic [7:0] CHAR_UC_P  = 8'h50;
   localparam logic [7:0] CHAR_LC_H  = 8'h68;

   // Register map.
   localparam logic [0:0] REG_ECHO_ENABLE = 1'b0;

   // Command queue depth.
   localparam int QueueDepth = 4;

   // Matcher stages.
   typedef enum logic [1:0] {
      STAGE_IDLE  = 2'd0,
      STAGE_ESC   = 2'd1,
      STAGE_CSI   = 2'd2,
      STAGE_DIGIT = 2'd3
   } stage_type;

   // What the back end emits after any flushed prefix.
   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_RAW    = 3'd1,
      ACT_LF     = 3'd2,
      ACT_RUBOUT = 3'd3,
      ACT_DELETE = 3'd4,
      ACT_INSERT = 3'd5
   } act_type;

   // One classified input item.
   typedef struct packed {
      logic [1:0] held_len;    // held prefix bytes to flush first
      logic       held_three;  // held digit is '3' rather than '2'
      act_type    act;
      logic [7:0] data;
   } cmd_type;

   // Number of bytes an action emits.
   function automatic logic [3:0] act_len(input act_type act);
      logic [3:0] len;
      unique case (act)
         ACT_RAW:    len = 4'd1;
         ACT_LF:     len = 4'd1;
         ACT_RUBOUT: len = 4'd6;
         ACT_DELETE: len = 4'd3;
         ACT_INSERT: len = 4'd4;
         default:    len = 4'd0;
      endcase
      return len;
   endfunction

   // Byte j of an action's output.
   function automatic logic [7:0] act_byte(input act_type act, input logic [2:0] j,
                                           input logic [7:0] data);
      logic [7:0] b;
      b = data;
      unique case (act)
         ACT_LF: b = CHAR_LF;
         ACT_RUBOUT: begin
            unique case (j)
               3'd0, 3'd3: b = CHAR_ESC;
               3'd1, 3'd4: b = CHAR_LBRK;
               3'd2:       b = CHAR_UC_D;
               default:    b = CHAR_UC_P;
            endcase
         end
         ACT_DELETE: begin
            unique case (j)
               3'd0:    b = CHAR_ESC;
               3'd1:    b = CHAR_LBRK;
               default: b = CHAR_UC_P;
            endcase
         end
         ACT_INSERT: begin
            unique case (j)
               3'd0:    b = CHAR_ESC;
               3'd1:    b = CHAR_LBRK;
               3'd2:    b = CHAR_FOUR;
               default: b = CHAR_LC_H;
            endcase
         end
         default: b = data;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

FILE: sv/teket_if.sv
`default_nettype none

// Input channel: one received byte per beat.
interface teket_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel: one echoed byte per beat.
interface teket_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last;

   modport source (output valid, output tx_byte, output last, input ready);
   modport sink   (input valid, input tx_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/teket_front.sv
`default_nettype none

module teket_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              echo_enable,
   input  wire logic              match_clear,
   teket_req_if.sink              req,
   output teket_pkg::cmd_type     push_cmd,
   output logic                   push_valid,
   input  wire logic              push_ready
);
   import teket_pkg::*;

   stage_type  stage_ff, stage_in;
   logic       three_ff, three_in;
   logic       accept;
   cmd_type    cmd;
   logic       idle_esc;
   act_type    idle_act;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   // Translation of a byte seen in the idle stage.
   always_comb begin
      idle_esc = 1'b0;
      priority if (req.rx_byte == CHAR_BS || req.rx_byte == CHAR_DEL) begin
         idle_act = ACT_RUBOUT;
      end else if (req.rx_byte == CHAR_ESC) begin
         idle_act = ACT_NONE;
         idle_esc = 1'b1;
      end else if (req.rx_byte == CHAR_CR) begin
         idle_act = ACT_LF;
      end else begin
         idle_act = ACT_RAW;
      end
   end

   // Matcher: classify the byte against the held prefix.
   always_comb begin
      cmd.held_len   = 2'd0;
      cmd.held_three = three_ff;
      cmd.act        = idle_act;
      cmd.data       = req.rx_byte;
      stage_in       = idle_esc ? STAGE_ESC : STAGE_IDLE;
      three_in       = 1'b0;
      unique case (stage_ff)
         STAGE_ESC: begin
            if (req.rx_byte == CHAR_LBRK) begin
               cmd.act  = ACT_NONE;
               stage_in = STAGE_CSI;
            end else begin
               cmd.held_len = 2'd1;
            end
         end
         STAGE_CSI: begin
            if (req.rx_byte == CHAR_TWO || req.rx_byte == CHAR_THREE) begin
               cmd.act  = ACT_NONE;
               stage_in = STAGE_DIGIT;
               three_in = (req.rx_byte == CHAR_THREE);
            end else begin
               cmd.held_len = 2'd2;
            end
         end
         STAGE_DIGIT: begin
            if (req.rx_byte == CHAR_TILDE) begin
               cmd.act  = three_ff ? ACT_DELETE : ACT_INSERT;
               stage_in = STAGE_IDLE;
            end else begin
               cmd.held_len = 2'd3;
            end
         end
         default: begin
         end
      endcase
   end

   assign push_cmd   = cmd;
   assign push_valid = accept && echo_enable &&
                       (cmd.held_len != 2'd0 || cmd.act != ACT_NONE);

   // Matcher state; disabled echo keeps it idle.
   always_ff @(posedge clock) begin
      if (reset || match_clear) begin
         stage_ff <= STAGE_IDLE;
         three_ff <= 1'b0;
      end else if (accept) begin
         if (echo_enable) begin
            stage_ff <= stage_in;
            three_ff <= three_in;
         end else begin
            stage_ff <= STAGE_IDLE;
            three_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/teket_queue.sv
`default_nettype none

module teket_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire teket_pkg::cmd_type push_cmd,
   input  wire logic              push_valid,
   output logic                   push_ready,
   output teket_pkg::cmd_type     pop_cmd,
   output logic                   pop_valid,
   input  wire logic              pop_ready
);
   import teket_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   cmd_type           entry_ff [QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != PtrW'(0) + (PtrW+1)'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

FILE: sv/teket_back.sv
`default_nettype none

module teket_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire teket_pkg::cmd_type pop_cmd,
   input  wire logic              pop_valid,
   output logic                   pop_ready,
   teket_rsp_if.source            rsp
);
   import teket_pkg::*;

   cmd_type     cur_ff, cur_in;
   logic [3:0]  idx_ff, idx_in;
   logic        busy_ff, busy_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        adv, fin;
   logic [3:0]  total;
   logic [3:0]  act_idx;
   logic [7:0]  cur_byte;

   // Total beats for the current command and the byte at the current index.
   always_comb begin
      total   = {2'b00, cur_ff.held_len} + act_len(cur_ff.act);
      act_idx = idx_ff - {2'b00, cur_ff.held_len};
      if (idx_ff < {2'b00, cur_ff.held_len}) begin
         unique case (idx_ff[1:0])
            2'd0:    cur_byte = CHAR_ESC;
            2'd1:    cur_byte = CHAR_LBRK;
            default: cur_byte = cur_ff.held_three ? CHAR_THREE : CHAR_TWO;
         endcase
      end else begin
         cur_byte = act_byte(cur_ff.act, act_idx[2:0], cur_ff.data);
      end
   end

   assign adv       = busy_ff && (!out_valid_ff || rsp.ready);
   assign fin       = adv && (idx_ff == total - 4'd1);
   assign pop_ready = !busy_ff || fin;

   // Sequencer and output register.
   always_comb begin
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (pop_valid && pop_ready) begin
         cur_in  = pop_cmd;
         idx_in  = 4'd0;
         busy_in = 1'b1;
      end else if (fin) begin
         busy_in = 1'b0;
      end else if (adv) begin
         idx_in = idx_ff + 4'd1;
      end
      if (adv) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = fin;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= 4'd0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.tx_byte = out_byte_ff;
   assign rsp.last    = out_last_ff;

endmodule

`default_nettype wire

FILE: sv/terminal_echo_key_translator.sv
// Console echo translator.
// The req channel takes one received console byte per beat; the rsp channel
// gives the bytes to echo, one per beat, with last set on the final byte
// that an input byte causes. Backspace and DEL expand to six bytes, CR
// becomes LF, and the Insert and Delete key sequences are rewritten. Bytes
// that only extend a held key prefix give no beats; a broken prefix is
// echoed raw ahead of the current byte's own output, up to nine beats.
// A front end classifies each byte in its accept cycle and posts a command
// to a four-entry queue; a back end expands commands into output beats.
// An item passes through a queue entry, the back end's command register
// and the output register; the back end sends one beat per cycle while
// the receiver is ready. The front end takes a byte every cycle while the
// queue has room. When the receiver stalls, the output register holds its
// beat and the queue fills before req.ready falls.
// Register 0 (echo_enable, byte address 0) resets to 1; writing 0 drops any
// held prefix and suppresses output. Reset empties the queue and the matcher.
`default_nettype none

module terminal_echo_key_translator (
   input  wire logic         clock,
   input  wire logic         reset,
   teket_req_if.sink         req,
   teket_rsp_if.source       rsp,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [2:0]   paddr,
   input  wire logic [31:0]  pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import teket_pkg::*;

   logic     echo_enable_ff, echo_enable_in;
   logic     cfg_write, cfg_hit, match_clear;
   cmd_type  push_cmd, pop_cmd;
   logic     push_valid, push_ready, pop_valid, pop_ready;

   // Register access.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign cfg_hit   = (paddr[2] == REG_ECHO_ENABLE);
   assign prdata    = cfg_hit ? {31'd0, echo_enable_ff} : 32'd0;

   always_comb begin
      echo_enable_in = echo_enable_ff;
      if (cfg_write && cfg_hit) begin
         echo_enable_in = pwdata[0];
      end
   end

   assign match_clear = cfg_write && cfg_hit && !pwdata[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_enable_ff <= 1'b1;
      end else begin
         echo_enable_ff <= echo_enable_in;
      end
   end

   // Front end, queue and back end.
   teket_front u_front (
      .clock       (clock),
      .reset       (reset),
      .echo_enable (echo_enable_ff),
      .match_clear (match_clear),
      .req         (req),
      .push_cmd    (push_cmd),
      .push_valid  (push_valid),
      .push_ready  (push_ready)
   );

   teket_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (push_cmd),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   teket_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_cmd   (pop_cmd),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import teket_pkg::*;

   // Register addresses on the configuration port.
   localparam logic [2:0] ADDR_ECHO_ENABLE = {REG_ECHO_ENABLE, 2'b00};
   localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASE_ITEMS   = 80;
   localparam int NUM_VECTORS   = 25;

   localparam logic [71:0] RUBOUT_BYTES =
      {CHAR_ESC, CHAR_LBRK, CHAR_UC_D, CHAR_ESC, CHAR_LBRK, CHAR_UC_P, 24'd0};

   // One echoed byte as it should appear on the result channel.
   typedef struct packed {
      logic [7:0] tx;
      logic       last;
   } echo_beat_type;

   // One directed input byte. Where typed is set, the bytes to echo are
   // given left-aligned in bytes; otherwise the translator model decides.
   typedef struct packed {
      logic [7:0]  rx;
      logic        typed;
      logic [3:0]  count;
      logic [71:0] bytes;
   } echo_vector_type;

   echo_vector_type echo_vectors [NUM_VECTORS] = '{
      '{8'h00,      1'b1, 4'd1, {8'h00, 64'd0}},
      '{8'hFF,      1'b1, 4'd1, {8'hFF, 64'd0}},
      '{CHAR_TILDE, 1'b0, 4'd0, 72'd0},
      '{CHAR_CR,    1'b1, 4'd1, {CHAR_LF, 64'd0}},
      '{CHAR_LF,    1'b1, 4'd1, {CHAR_LF, 64'd0}},
      '{CHAR_BS,    1'b1, 4'd6, RUBOUT_BYTES},
      '{CHAR_DEL,   1'b1, 4'd6, RUBOUT_BYTES},
      // Insert key.
      '{CHAR_ESC,   1'b1, 4'd0, 72'd0},
      '{CHAR_LBRK,  1'b1, 4'd0, 72'd0},
      '{CHAR_TWO,   1'b1, 4'd0, 72'd0},
      '{CHAR_TILDE, 1'b1, 4'd4, {CHAR_ESC, CHAR_LBRK, CHAR_FOUR, CHAR_LC_H, 40'd0}},
      // Delete key.
      '{CHAR_ESC,   1'b1, 4'd0, 72'd0},
      '{CHAR_LBRK,  1'b1, 4'd0, 72'd0},
      '{CHAR_THREE, 1'b1, 4'd0, 72'd0},
      '{CHAR_TILDE, 1'b1, 4'd3, {CHAR_ESC, CHAR_LBRK, CHAR_UC_P, 48'd0}},
      // Prefix broken right after ESC.
      '{CHAR_ESC,   1'b0, 4'd0, 72'd0},
      '{8'h41,      1'b0, 4'd0, 72'd0},
      // Prefix broken after ESC [ by a new ESC, which starts over.
      '{CHAR_ESC,   1'b0, 4'd0, 72'd0},
      '{CHAR_LBRK,  1'b0, 4'd0, 72'd0},
      '{CHAR_ESC,   1'b0, 4'd0, 72'd0},
      '{CHAR_LBRK,  1'b0, 4'd0, 72'd0},
      '{CHAR_TWO,   1'b0, 4'd0, 72'd0},
      // Full prefix flushed ahead of a rubout: the longest output.
      '{CHAR_DEL,   1'b1, 4'd9, {CHAR_ESC, CHAR_LBRK, CHAR_TWO, RUBOUT_BYTES[71:24]}},
      // Left held for the register write that drops it.
      '{CHAR_ESC,   1'b0, 4'd0, 72'd0},
      '{CHAR_LBRK,  1'b0, 4'd0, 72'd0}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   teket_req_if req_ch ();
   teket_rsp_if rsp_ch ();

   terminal_echo_key_translator dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Translator model state and the echo bytes still owed by the block.
   logic          echo_on;
   stage_type     key_stage;
   logic          key_digit_three;
   echo_beat_type echo_scratch [$];
   echo_beat_type echo_expected [$];

   int mismatch_count  = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_off_cycles = 0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   function automatic void emit_byte(input logic [7:0] b);
      echo_beat_type nb;
      nb.tx   = b;
      nb.last = 1'b0;
      echo_scratch.push_back(nb);
   endfunction

   function automatic void emit_rubout();
      emit_byte(CHAR_ESC);
      emit_byte(CHAR_LBRK);
      emit_byte(CHAR_UC_D);
      emit_byte(CHAR_ESC);
      emit_byte(CHAR_LBRK);
      emit_byte(CHAR_UC_P);
   endfunction

   // Echo the held key prefix raw and go back to idle.
   function automatic void flush_key_prefix();
      if (key_stage >= STAGE_ESC) begin
         emit_byte(CHAR_ESC);
      end
      if (key_stage >= STAGE_CSI) begin
         emit_byte(CHAR_LBRK);
      end
      if (key_stage == STAGE_DIGIT) begin
         emit_byte(key_digit_three ? CHAR_THREE : CHAR_TWO);
      end
      key_stage       = STAGE_IDLE;
      key_digit_three = 1'b0;
   endfunction

   function automatic void translate_idle(input logic [7:0] b);
      if (b == CHAR_BS || b == CHAR_DEL) begin
         emit_rubout();
      end else if (b == CHAR_ESC) begin
         key_stage = STAGE_ESC;
      end else if (b == CHAR_CR) begin
         emit_byte(CHAR_LF);
      end else begin
         emit_byte(b);
      end
   endfunction

   // Work out the bytes echoed for one received byte into echo_scratch.
   function automatic void translate_byte(input logic [7:0] b);
      echo_scratch.delete();
      if (!echo_on) begin
         key_stage       = STAGE_IDLE;
         key_digit_three = 1'b0;
         return;
      end
      case (key_stage)
         STAGE_ESC: begin
            if (b == CHAR_LBRK) begin
               key_stage = STAGE_CSI;
            end else begin
               flush_key_prefix();
               translate_idle(b);
            end
         end
         STAGE_CSI: begin
            if (b == CHAR_TWO || b == CHAR_THREE) begin
               key_stage       = STAGE_DIGIT;
               key_digit_three = (b == CHAR_THREE);
            end else begin
               flush_key_prefix();
               translate_idle(b);
            end
         end
         STAGE_DIGIT: begin
            if (b == CHAR_TILDE) begin
               if (key_digit_three) begin
                  emit_byte(CHAR_ESC);
                  emit_byte(CHAR_LBRK);
                  emit_byte(CHAR_UC_P);
               end else begin
                  emit_byte(CHAR_ESC);
                  emit_byte(CHAR_LBRK);
                  emit_byte(CHAR_FOUR);
                  emit_byte(CHAR_LC_H);
               end
               key_stage       = STAGE_IDLE;
               key_digit_three = 1'b0;
            end else begin
               flush_key_prefix();
               translate_idle(b);
            end
         end
         default: begin
            key_stage = STAGE_IDLE;
            translate_idle(b);
         end
      endcase
      if (echo_scratch.size() > 0) begin
         echo_scratch[echo_scratch.size() - 1].last = 1'b1;
      end
   endfunction

   function automatic void apply_register_write(input logic [2:0] addr,
                                                input logic [31:0] data);
      if (addr == ADDR_ECHO_ENABLE) begin
         echo_on = data[0];
         if (!echo_on) begin
            key_stage       = STAGE_IDLE;
            key_digit_three = 1'b0;
         end
      end
   endfunction

   // Offer one byte, wait for the beat to be taken, and queue its echo.
   task automatic send_byte(input logic [7:0]  b,
                            input logic        typed = 1'b0,
                            input logic [3:0]  count = 4'd0,
                            input logic [71:0] bytes = 72'd0);
      echo_beat_type nb;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      translate_byte(b);
      if (typed) begin
         for (int k = 0; k < count; k++) begin
            nb.tx   = bytes[71 - 8 * k -: 8];
            nb.last = (k == count - 1);
            echo_expected.push_back(nb);
         end
      end else begin
         foreach (echo_scratch[k]) begin
            echo_expected.push_back(echo_scratch[k]);
         end
      end
   endtask

   // One random run of input: key sequences, whole or broken, half the time.
   task automatic send_random_burst(inout int sent);
      logic [7:0] seq [$];
      logic [7:0] digit;
      int         kind;
      int         held;
      kind  = $urandom_range(0, 9);
      digit = $urandom_range(0, 1) ? CHAR_THREE : CHAR_TWO;
      held  = $urandom_range(1, 3);
      case (kind)
         0, 1, 2: begin
            seq.push_back(CHAR_ESC);
            seq.push_back(CHAR_LBRK);
            seq.push_back(digit);
            seq.push_back(CHAR_TILDE);
         end
         3, 6: begin
            seq.push_back(CHAR_ESC);
            if (held >= 2) begin
               seq.push_back(CHAR_LBRK);
            end
            if (held >= 3) begin
               seq.push_back(digit);
            end
            if (kind == 3) begin
               seq.push_back(8'($urandom_range(0, 255)));
            end else begin
               case ($urandom_range(0, 3))
                  0:       seq.push_back(CHAR_ESC);
                  1:       seq.push_back(CHAR_BS);
                  2:       seq.push_back(CHAR_DEL);
                  default: seq.push_back(CHAR_CR);
               endcase
            end
         end
         4: seq.push_back($urandom_range(0, 1) ? CHAR_DEL : CHAR_BS);
         5: seq.push_back(CHAR_CR);
         default: seq.push_back(8'($urandom_range(0, 255)));
      endcase
      foreach (seq[k]) begin
         send_byte(seq[k]);
      end
      sent += seq.size();
   endtask

   // Stop offering bytes and let every owed echo come out.
   task automatic settle_block();
      int waited;
      waited = 0;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (echo_expected.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      apply_register_write(addr, data);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic check_echo_enable(input logic expected);
      logic [31:0] value;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_ECHO_ENABLE;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      value = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (value !== {31'd0, expected}) begin
         report_mismatch($sformatf("echo_enable reads 0x%08h, expected %0b",
                                   value, expected));
      end
   endtask

   // Result side: random stalls, plus a long hold-off when one is asked for.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Compare each echoed beat with the oldest owed one.
   always @(posedge clock) begin
      echo_beat_type owed;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (echo_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected echo beat 0x%02h last %0b",
                                      rsp_ch.tx_byte, rsp_ch.last));
         end else begin
            owed = echo_expected.pop_front();
            if (rsp_ch.tx_byte !== owed.tx) begin
               report_mismatch($sformatf("tx_byte 0x%02h, expected 0x%02h",
                                         rsp_ch.tx_byte, owed.tx));
            end
            if (rsp_ch.last !== owed.last) begin
               report_mismatch($sformatf("last %0b on byte 0x%02h, expected %0b",
                                         rsp_ch.last, rsp_ch.tx_byte, owed.last));
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("terminal_echo_key_translator: mismatch");
      $finish;
   end

   initial begin
      int            sent;
      echo_beat_type owed;
      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req_ch.valid    = 1'b0;
      req_ch.rx_byte  = '0;
      echo_on         = 1'b1;
      key_stage       = STAGE_IDLE;
      key_digit_three = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_echo_enable(1'b1);

      // Directed bytes, back to back.
      for (int i = 0; i < NUM_VECTORS; i++) begin
         send_byte(echo_vectors[i].rx, echo_vectors[i].typed,
                   echo_vectors[i].count, echo_vectors[i].bytes);
      end
      settle_block();

      // Turning echo off drops the held ESC [, so the tilde comes back raw.
      csr_write(ADDR_ECHO_ENABLE, 32'h0000_0000);
      csr_write(ADDR_ECHO_ENABLE, 32'h0000_0001);
      send_byte(CHAR_TILDE);
      settle_block();

      // A write to an unmapped register changes nothing.
      csr_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
      check_echo_enable(1'b1);

      // Random phases under different idling patterns.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_random_burst(sent);
         end
         settle_block();

         if (phase == 1) begin
            // Echo off: all bytes are swallowed and the matcher stays idle.
            csr_write(ADDR_ECHO_ENABLE, 32'hFFFF_FFFE);
            check_echo_enable(1'b0);
            sent = 0;
            while (sent < 30) begin
               send_random_burst(sent);
            end
            settle_block();
            csr_write(ADDR_ECHO_ENABLE, 32'hFFFF_FFFF);
            check_echo_enable(1'b1);
         end
      end

      // Long receiver hold-off while bytes keep coming, so the input stalls.
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 150;
      sent = 0;
      while (sent < 40) begin
         send_random_burst(sent);
      end
      settle_block();

      while (echo_expected.size() != 0) begin
         owed = echo_expected.pop_front();
         report_mismatch($sformatf("echo byte 0x%02h last %0b never came",
                                   owed.tx, owed.last));
      end
      if (mismatch_count == 0) begin
         $display("terminal_echo_key_translator: match");
      end else begin
         $display("terminal_echo_key_translator: mismatch");
      end
      $finish;
   end

endmodule
